// ===== hw/rtl/tvs_pkg.sv =====
// Package for the trapezoidal velocity step: configuration register indexes,
// reset values, fixed-point constants and the profile case codes.
// Depends on nothing; imported by trapezoid_velocity_step.
package tvs_pkg;

  // Configuration registers are unsigned Q15.16, 31 bits wide
  localparam int CFG_WIDTH = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCELERATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD      = 2'd2;

  localparam logic [CFG_WIDTH-1:0] RST_MAX_VELOCITY     = 31'd655360;
  localparam logic [CFG_WIDTH-1:0] RST_MAX_ACCELERATION = 31'd131072;
  localparam logic [CFG_WIDTH-1:0] RST_STEP_PERIOD      = 31'd2185;

  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  // Clamped velocities stay within +-max_velocity, so 32 signed bits hold them
  localparam int VEL_W = 32;

  typedef enum logic [2:0] {
    CASE_REST,
    CASE_ACC_CRUISE_DEC,
    CASE_DEC_CRUISE_ACC,
    CASE_ACC_DEC,
    CASE_DEC_ACC
  } profile_case_t;

endpackage

// ===== hw/rtl/trapezoid_velocity_step.sv =====
// Trapezoidal velocity step: one control period of a bang-bang profile,
// ten-stage pipeline with per-stage valid bits and ready chain.
// Depends on tvs_pkg.
//
//   channel | signals                                       | transaction
//   --------+-----------------------------------------------+--------------------------
//   in      | in_valid in_ready distance start/end_velocity | in_valid & in_ready
//   out     | out_valid out_ready next_velocity profile_case| out_valid & out_ready
//   cfg     | cfg_write cfg_index cfg_data                  | cfg_write, no wait
//
// One transaction per cycle enters while out_ready does not hold the pipeline back.
// The depth is set by the 32x32 partial-product multipliers, their
// sign and sum stages and the wide profile compares, one per stage.
// Reset empties the pipeline and loads the register defaults.
// A stage holds while the next one is full and not advancing; empty stages
// keep filling, so input is taken while a finished result waits.
module trapezoid_velocity_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_WIDTH-1:0]       distance,
  input  logic signed [VALUE_WIDTH-1:0]       start_velocity,
  input  logic signed [VALUE_WIDTH-1:0]       end_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [VALUE_WIDTH-1:0]       next_velocity,
  output tvs_pkg::profile_case_t              profile_case,
  input  logic                                cfg_write,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvs_pkg::CFG_WIDTH-1:0]       cfg_data
);
  import tvs_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int NS   = 10;
  localparam int NP   = 5;
  localparam int XW   = (W > VEL_W ? W : VEL_W) + 1;
  localparam int FW   = VEL_W + 2;
  localparam int MW   = 2 * VEL_W + 1;
  localparam int NC   = (W + 31) / 32;
  localparam int SXW  = NC * 32;
  localparam int LPW  = SXW + 32;
  localparam int CW   = (LPW > MW + 1 ? LPW : MW + 1) + 1;
  localparam int PW   = 2 * CFG_WIDTH;
  localparam int STW  = PW - FRAC_BITS;
  localparam int RW   = STW + 3;
  localparam int SATW = W > RW ? W : RW;

  localparam logic signed [SATW-1:0] SAT_HI = $signed({{(SATW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SATW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic                          rest;
    logic                          mirror;
    logic                          up;
    profile_case_t                 pcase;
    logic [W-1:0]                  s;
    logic signed [VEL_W-1:0]       v0;
    logic signed [VEL_W-1:0]       v1;
    logic [NP-1:0][VEL_W-1:0]      u;
    logic [NP-1:0][FW-1:0]         f;
    logic [NP-1:0][VEL_W:0]        bmag;
    logic [NP-1:0]                 bneg;
    logic [NP-1:0][2*VEL_W-1:0]    plo;
    logic [NP-1:0][MW-1:0]         mag;
    logic [NP-1:0][MW:0]           prod;
    logic [NC-1:0][63:0]           pp;
    logic [LPW-1:0]                lhs;
    logic signed [CW-1:0]          n1;
    logic signed [CW-1:0]          n2;
    logic signed [CW-1:0]          n3;
    logic [W-1:0]                  result;
  } stage_t;

  logic [CFG_WIDTH-1:0] max_velocity;
  logic [CFG_WIDTH-1:0] max_acceleration;
  logic [CFG_WIDTH-1:0] step_period;
  logic [PW-1:0]        step_prod;

  stage_t          st [NS];
  stage_t          nx [NS];
  logic [NS-1:0]   vld;
  logic [NS-1:0]   rdy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity     <= RST_MAX_VELOCITY;
      max_acceleration <= RST_MAX_ACCELERATION;
      step_period      <= RST_STEP_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_VELOCITY:     max_velocity     <= cfg_data;
        REG_MAX_ACCELERATION: max_acceleration <= cfg_data;
        REG_STEP_PERIOD:      step_period      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step size product follows the registers, settled long before use
  always_ff @(posedge clk) begin
    step_prod <= max_acceleration * step_period;
  end

  // Ready chain: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld[NS-1];
  assign next_velocity = st[NS-1].result;
  assign profile_case  = st[NS-1].pcase;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st[k] <= nx[k];
      end
    end
  end

  always_comb begin
    logic signed [XW-1:0]   lim;
    logic signed [XW-1:0]   d0;
    logic signed [XW-1:0]   d1;
    logic signed [FW-1:0]   vm;
    logic signed [FW-1:0]   w0;
    logic signed [FW-1:0]   w1;
    logic signed [FW-1:0]   dv;
    logic signed [FW-1:0]   fk;
    logic [SXW-1:0]         s_ext;
    logic [31:0]            acc2;
    logic [LPW-1:0]         lhs_acc;
    logic signed [CW-1:0]   lhs_s;
    logic [STW-1:0]         step;
    logic signed [RW-1:0]   rv;
    logic signed [RW-1:0]   rr;
    logic signed [SATW-1:0] rs;
    logic signed [SATW-1:0] clip;

    // Stage 0: rest test, mirror flag, |distance|, clamp both velocities
    nx[0]        = '0;
    nx[0].pcase  = CASE_REST;
    nx[0].rest   = (distance == '0) && (start_velocity == end_velocity);
    nx[0].mirror = distance[W-1];
    nx[0].s      = distance[W-1] ? (~distance + W'(1)) : distance;
    lim = $signed(XW'(max_velocity));
    d0  = XW'(start_velocity);
    d1  = XW'(end_velocity);
    if (d0 > lim) begin
      d0 = lim;
    end else if (d0 < -lim) begin
      d0 = -lim;
    end
    if (d1 > lim) begin
      d1 = lim;
    end else if (d1 < -lim) begin
      d1 = -lim;
    end
    nx[0].v0 = d0[VEL_W-1:0];
    nx[0].v1 = d1[VEL_W-1:0];

    // Stage 1: mirror velocities for a negative distance
    nx[1] = st[0];
    if (st[0].mirror) begin
      nx[1].v0 = -st[0].v0;
      nx[1].v1 = -st[0].v1;
    end

    // Stage 2: factors of the five products behind the three boundary sums
    nx[2] = st[1];
    vm = $signed(FW'(max_velocity));
    w0 = FW'(st[1].v0);
    w1 = FW'(st[1].v1);
    dv = (w1 > w0) ? (w1 - w0) : (w0 - w1);
    nx[2].u[0] = VEL_W'(vm - w0);
    nx[2].f[0] = vm + w0;
    nx[2].u[1] = VEL_W'(vm - w1);
    nx[2].f[1] = (w1 <<< 1) + w1 - vm;
    nx[2].u[2] = VEL_W'(w0 + vm);
    nx[2].f[2] = (w1 <<< 1) - w0 - vm;
    nx[2].u[3] = VEL_W'(w1 + vm);
    nx[2].f[3] = w1 + vm + (w0 <<< 1);
    nx[2].u[4] = VEL_W'(dv);
    nx[2].f[4] = dv + (w0 <<< 1);

    // Stage 3: signed factors to sign and magnitude
    nx[3] = st[2];
    for (int k = 0; k < NP; k++) begin
      fk = $signed(st[2].f[k]);
      nx[3].bneg[k] = fk[FW-1];
      nx[3].bmag[k] = fk[FW-1] ? (VEL_W+1)'(-fk) : (VEL_W+1)'(fk);
    end

    // Stage 4: 32x32 partial products
    nx[4] = st[3];
    for (int k = 0; k < NP; k++) begin
      nx[4].plo[k] = st[3].u[k] * st[3].bmag[k][VEL_W-1:0];
    end
    s_ext = SXW'(st[3].s);
    acc2  = {max_acceleration, 1'b0};
    for (int c = 0; c < NC; c++) begin
      nx[4].pp[c] = acc2 * s_ext[32*c +: 32];
    end

    // Stage 5: fold in the top magnitude bit, sum the distance chunks
    nx[5] = st[4];
    for (int k = 0; k < NP; k++) begin
      nx[5].mag[k] = MW'(st[4].plo[k])
                   + (st[4].bmag[k][VEL_W] ? {1'b0, st[4].u[k], 32'b0} : MW'(0));
    end
    lhs_acc = '0;
    for (int c = 0; c < NC; c++) begin
      lhs_acc = lhs_acc + (LPW'(st[4].pp[c]) << (32 * c));
    end
    nx[5].lhs = lhs_acc;

    // Stage 6: apply product signs
    nx[6] = st[5];
    for (int k = 0; k < NP; k++) begin
      nx[6].prod[k] = st[5].bneg[k] ? (~{1'b0, st[5].mag[k]} + (MW+1)'(1))
                                     : {1'b0, st[5].mag[k]};
    end

    // Stage 7: boundary sums
    nx[7] = st[6];
    nx[7].n1 = CW'($signed(st[6].prod[0])) + CW'($signed(st[6].prod[1]));
    nx[7].n2 = CW'($signed(st[6].prod[2])) + CW'($signed(st[6].prod[3]));
    nx[7].n3 = CW'($signed(st[6].prod[4]));

    // Stage 8: pick the profile case
    nx[8] = st[7];
    lhs_s = $signed(CW'(st[7].lhs));
    priority if (st[7].rest) begin
      nx[8].pcase = CASE_REST;
      nx[8].up    = 1'b0;
    end else if (st[7].n1 < lhs_s) begin
      nx[8].pcase = CASE_ACC_CRUISE_DEC;
      nx[8].up    = 1'b1;
    end else if (lhs_s < st[7].n2) begin
      nx[8].pcase = CASE_DEC_CRUISE_ACC;
      nx[8].up    = 1'b0;
    end else if (!(lhs_s < st[7].n3)) begin
      nx[8].pcase = CASE_ACC_DEC;
      nx[8].up    = 1'b1;
    end else begin
      nx[8].pcase = CASE_DEC_ACC;
      nx[8].up    = 1'b0;
    end

    // Stage 9: add or subtract the rounded step, undo mirror, saturate, zero at rest
    nx[9] = st[8];
    step = STW'((step_prod + PW'(ROUND_HALF)) >> FRAC_BITS);
    rv = st[8].up ? (RW'(st[8].v0) + $signed(RW'(step)))
                  : (RW'(st[8].v0) - $signed(RW'(step)));
    rr = st[8].mirror ? -rv : rv;
    rs = SATW'(rr);
    if (rs > SAT_HI) begin
      clip = SAT_HI;
    end else if (rs < SAT_LO) begin
      clip = SAT_LO;
    end else begin
      clip = rs;
    end
    nx[9].result = st[8].rest ? '0 : clip[W-1:0];
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for trapezoid_velocity_step: random and corner-case queries
// against a built-in profile predictor, with randomized valid/ready gaps.
// Depends on tvs_pkg and the trapezoid_velocity_step RTL.
module tb;
  import tvs_pkg::*;

  localparam int VW = 32;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 128;
  localparam int QUIET_PHASE = 2;
  localparam int HOLD_PHASE = 3;
  localparam int HOLD_LENGTH = 150;
  localparam int TAIL_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_CAP = 100;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [VW-1:0] next_velocity;
    profile_case_t        profile_case;
  } step_result_t;

  localparam wide_t VEL_TOP = (wide_t'(1) <<< (VW - 1)) - 1;
  localparam wide_t VEL_BOTTOM = -VEL_TOP - 1;

  class velocity_scoreboard;
    logic [CFG_WIDTH-1:0] vel_limit, accel_limit, period;
    step_result_t         expected_steps[$];
    int                   mismatches, checked, queries;
    int                   case_hits[5];

    function new();
      vel_limit = RST_MAX_VELOCITY;
      accel_limit = RST_MAX_ACCELERATION;
      period = RST_STEP_PERIOD;
    endfunction

    function void set_limits(logic [CFG_WIDTH-1:0] v, a, t);
      vel_limit = v;
      accel_limit = a;
      period = t;
    endfunction

    // Distance tests are done as 2*A*s against the squared-velocity terms, so
    // everything stays exact in wide integers.
    function step_result_t predict_step(logic signed [VW-1:0] remaining, v_start, v_end);
      wide_t        vm, acc, per, s, v0, v1, dv, lhs, rhs, step, vel;
      bit           mirror, speed_up;
      step_result_t r;
      if (remaining == 0 && v_start == v_end) begin
        r.next_velocity = '0;
        r.profile_case = CASE_REST;
        return r;
      end
      vm = vel_limit;
      acc = accel_limit;
      per = period;
      mirror = remaining < 0;
      s = remaining;
      if (mirror) s = -s;
      v0 = v_start;
      v1 = v_end;
      if (v0 > vm) v0 = vm;
      else if (v0 < -vm) v0 = -vm;
      if (v1 > vm) v1 = vm;
      else if (v1 < -vm) v1 = -vm;
      if (mirror) begin
        v0 = -v0;
        v1 = -v1;
      end
      lhs = 2 * acc * s;
      rhs = (vm - v0) * (vm + v0) + (vm - v1) * (3 * v1 - vm);
      if (rhs < lhs) begin
        speed_up = 1'b1;
        r.profile_case = CASE_ACC_CRUISE_DEC;
      end else begin
        rhs = (v0 + vm) * (2 * v1 - v0 - vm) + (v1 + vm) * (v1 + vm + 2 * v0);
        if (lhs < rhs) begin
          speed_up = 1'b0;
          r.profile_case = CASE_DEC_CRUISE_ACC;
        end else begin
          dv = (v1 > v0) ? v1 - v0 : v0 - v1;
          rhs = dv * (dv + 2 * v0);
          speed_up = !(lhs < rhs);
          r.profile_case = speed_up ? CASE_ACC_DEC : CASE_DEC_ACC;
        end
      end
      step = (acc * per + ROUND_HALF) >> FRAC_BITS;
      vel = speed_up ? v0 + step : v0 - step;
      if (mirror) vel = -vel;
      if (vel > VEL_TOP) vel = VEL_TOP;
      if (vel < VEL_BOTTOM) vel = VEL_BOTTOM;
      r.next_velocity = vel[VW-1:0];
      return r;
    endfunction

    function void note_query(logic signed [VW-1:0] remaining, v_start, v_end);
      step_result_t want;
      want = predict_step(remaining, v_start, v_end);
      expected_steps.push_back(want);
      case_hits[int'(want.profile_case)]++;
      queries++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(logic signed [VW-1:0] vel, profile_case_t pc);
      step_result_t want;
      if (expected_steps.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with nothing pending", vel, pc));
        return;
      end
      want = expected_steps.pop_front();
      checked++;
      if (vel !== want.next_velocity)
        report_mismatch($sformatf("result %0d: next_velocity %0d, want %0d",
                                  checked, vel, want.next_velocity));
      if (pc !== want.profile_case)
        report_mismatch($sformatf("result %0d: profile_case %0d, want %0d",
                                  checked, pc, want.profile_case));
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [VW-1:0] distance = '0;
  logic signed [VW-1:0] start_velocity = '0;
  logic signed [VW-1:0] end_velocity = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW-1:0] next_velocity;
  profile_case_t        profile_case;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_VELOCITY;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  velocity_scoreboard board = new();
  bit idling_on = 1'b1;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  trapezoid_velocity_step #(.VALUE_WIDTH(VW)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_query(logic signed [VW-1:0] d, vs, ve);
    while (idling_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    distance <= d;
    start_velocity <= vs;
    end_velocity <= ve;
    do @(posedge clk); while (!in_ready);
    board.note_query(d, vs, ve);
    @(negedge clk);
  endtask

  function automatic logic signed [VW-1:0] pick_signed(longint lim);
    longint unsigned raw;
    longint          r;
    raw = {$urandom(), $urandom()};
    r = longint'(raw % longint'(2 * lim + 1)) - lim;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[VW-1:0];
  endfunction

  // Most queries keep velocities near the limit and distances near the
  // braking distance so that every profile case is reached.
  task automatic random_query(output logic signed [VW-1:0] d, vs, ve);
    longint vm, span, reach;
    int     pick;
    vm = board.vel_limit;
    span = vm + vm / 4 + 16;
    reach = (vm * vm) / (2 * longint'(board.accel_limit));
    if (reach > 64'sh1FFF_FFFF) reach = 64'sh7FFF_FFFF;
    else reach = reach * 3 + 64;
    pick = $urandom_range(99);
    if (pick < 15) begin
      d = $urandom();
      vs = $urandom();
      ve = $urandom();
    end else if (pick < 22) begin
      d = '0;
      vs = pick_signed(span);
      ve = $urandom_range(1) ? vs : pick_signed(span);
    end else begin
      d = pick_signed(reach);
      vs = pick_signed(span);
      ve = pick_signed(span);
    end
  endtask

  task automatic load_limits(logic [CFG_WIDTH-1:0] v, a, t);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_VELOCITY;
    cfg_data <= v;
    @(negedge clk);
    cfg_index <= REG_MAX_ACCELERATION;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= REG_STEP_PERIOD;
    cfg_data <= t;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_limits(v, a, t);
  endtask

  // Returns at a rising edge once every expected result has been taken.
  task automatic wait_for_drain();
    do @(posedge clk); while (board.expected_steps.size() != 0);
  endtask

  // Receiver: random back-pressure plus an optional long hold.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= !(idling_on && $urandom_range(99) < 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(next_velocity, profile_case);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, board.expected_steps.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [VW-1:0] d, vs, ve;
    logic [CFG_WIDTH-1:0] lim_v, lim_a, lim_t;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_for_drain();
        if (p == HOLD_PHASE) hold_cycles = HOLD_LENGTH;
        @(negedge clk);
        case (p)
          1: begin lim_v = '1; lim_a = '1; lim_t = '1; end
          2: begin lim_v = '0; lim_a = 1; lim_t = 1; end
          3: begin lim_v = RST_MAX_VELOCITY; lim_a = 1; lim_t = '1; end
          4: begin lim_v = '1; lim_a = 1; lim_t = 65536; end
          5, 6: begin
            lim_v = CFG_WIDTH'($urandom_range(1 << 22, 1));
            lim_a = CFG_WIDTH'($urandom_range(1 << 20, 1));
            lim_t = CFG_WIDTH'($urandom_range(1 << 17, 1));
          end
          default: begin
            lim_v = CFG_WIDTH'($urandom());
            lim_a = CFG_WIDTH'($urandom_range(32'h7FFF_FFFF, 1));
            lim_t = CFG_WIDTH'($urandom_range(32'h7FFF_FFFF, 1));
          end
        endcase
        load_limits(lim_v, lim_a, lim_t);
      end
      idling_on = (p != QUIET_PHASE);
      if (p == 0) begin
        // rest, including raw-equal velocities far outside the limit
        send_query(0, 0, 0);
        send_query(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_query(0, 32'sh8000_0000, 32'sh8000_0000);
        // zero distance with unequal velocities
        send_query(0, 65536, -65536);
        send_query(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // distance extremes, mirrored and not
        send_query(32'sh7FFF_FFFF, 0, 0);
        send_query(32'sh8000_0000, 0, 0);
        send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_query(1, 655360, 0);
        send_query(-1, -655360, 0);
        send_query(1, 0, 0);
        send_query(-1, 0, 0);
        send_query(65536, 0, 655360);
        send_query(-65536, 0, -655360);
        send_query(1638400, 0, 0);
        send_query(3276800, -655360, 655360);
        send_query(-3276800, 655360, -655360);
        send_query(100, 655360, 655360);
        send_query(655360, 655361, -655361);
        send_query(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333);
        send_query(32'shAAAA_AAAA, 32'sh5555_5555, 32'shCCCC_CCCC);
      end
      repeat (RANDOM_PER_PHASE) begin
        random_query(d, vs, ve);
        send_query(d, vs, ve);
      end
      in_valid <= 1'b0;
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.expected_steps.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived",
                                      board.expected_steps.size()));
    $display("Ran %0d queries over %0d limit settings (defaults, extremes, random); %0d checked",
             board.queries, PHASES, board.checked);
    $display("Profile cases: rest %0d, acc-cruise-dec %0d, dec-cruise-acc %0d, acc-dec %0d, dec-acc %0d",
             board.case_hits[0], board.case_hits[1], board.case_hits[2],
             board.case_hits[3], board.case_hits[4]);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== trapezoid_velocity_step.f =====
hw/rtl/tvs_pkg.sv
hw/rtl/trapezoid_velocity_step.sv
test/tb.sv
